// ----- sv/bslpc_pkg.sv -----
// Shared types and constants for the button short/long press classifier.
package bslpc_pkg;

  // Fixed field widths.
  localparam int IDX_W  = 4;
  localparam int TIME_W = 32;
  localparam int DUR_W  = 16;

  // Configuration port geometry.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register index codes, taken from the word address bit.
  localparam logic REG_LONG_PRESS = 1'b0;

  // Reset value of the long press duration in milliseconds.
  localparam logic [DUR_W-1:0] LONG_PRESS_RESET = 16'd1000;

  // Events produced for one item.
  typedef struct packed {
    logic press_edge;
    logic release_edge;
    logic short_press;
    logic long_press;
    logic index_invalid;
  } bslpc_evt_t;

endpackage

// ----- sv/bslpc_track.sv -----
// Per-button press state and the event decode for one sample.
module bslpc_track #(
  parameter int BUTTON_COUNT = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          commit_i,
  input  logic [bslpc_pkg::IDX_W-1:0]   index_i,
  input  logic                          level_i,
  input  logic [bslpc_pkg::TIME_W-1:0]  now_ms_i,
  input  logic [bslpc_pkg::DUR_W-1:0]   long_press_ms_i,
  output bslpc_pkg::bslpc_evt_t         evt_o
);
  import bslpc_pkg::*;

  // Only indices the 4-bit field can reach need storage.
  localparam int DEPTH = (BUTTON_COUNT < (1 << IDX_W)) ? BUTTON_COUNT : (1 << IDX_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              active_q [DEPTH];
  logic              long_q   [DEPTH];
  logic [TIME_W-1:0] start_q  [DEPTH];

  logic              in_range;
  logic [AW-1:0]     addr;
  logic              pressed;
  logic              rd_active;
  logic              rd_long;
  logic [TIME_W-1:0] rd_start;
  logic [TIME_W-1:0] elapsed;
  logic              reached;

  // Look up the addressed button.
  assign in_range  = int'(index_i) < BUTTON_COUNT;
  assign addr      = index_i[AW-1:0];
  assign pressed   = ~level_i;
  assign rd_active = in_range ? active_q[addr] : 1'b0;
  assign rd_long   = in_range ? long_q[addr] : 1'b0;
  assign rd_start  = in_range ? start_q[addr] : '0;

  // Hold time modulo 2^32 against the configured duration.
  assign elapsed = now_ms_i - rd_start;
  assign reached = elapsed >= {{(TIME_W-DUR_W){1'b0}}, long_press_ms_i};

  // Event decode.
  always_comb begin
    evt_o.index_invalid = ~in_range;
    evt_o.press_edge    = in_range & pressed & ~rd_active;
    evt_o.long_press    = in_range & pressed & rd_active & ~rd_long & reached;
    evt_o.release_edge  = in_range & ~pressed & rd_active;
    evt_o.short_press   = in_range & ~pressed & rd_active & ~rd_long;
  end

  // Flag update for the committed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        active_q[i] <= 1'b0;
        long_q[i]   <= 1'b0;
      end
    end else if (commit_i && in_range) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (addr == AW'(i)) begin
          if (!pressed) begin
            active_q[i] <= 1'b0;
            long_q[i]   <= 1'b0;
          end else if (!rd_active) begin
            active_q[i] <= 1'b1;
            long_q[i]   <= 1'b0;
          end else if (evt_o.long_press) begin
            long_q[i] <= 1'b1;
          end
        end
      end
    end
  end

  // Start time is only read while the press is active, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (commit_i && in_range && pressed && !rd_active) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (addr == AW'(i)) begin
          start_q[i] <= now_ms_i;
        end
      end
    end
  end

endmodule

// ----- sv/button_short_long_press_classifier.sv -----
// Top level of the button short/long press classifier.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_stall_o   button_index_i, level_i, now_ms_i
//   out       output     out_valid_o / out_stall_i result_index_o and five event flags
//   config    input      APB write and read        long_press_ms at byte address 0
//
// Each item yields one result via the input register; the state lookup and event
// decode then feed the result register. One item per cycle is sustained while the
// result is not stalled; the per-button state is updated as the item moves into
// the result register, so consecutive items for one button see each other. A
// stalled result holds the result register and the input register keeps one more
// item. Reset clears all press flags and loads a duration of 1000 ms.
module button_short_long_press_classifier #(
  parameter int BUTTON_COUNT = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Sample channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [bslpc_pkg::IDX_W-1:0]        button_index_i,
  input  logic                               level_i,
  input  logic [bslpc_pkg::TIME_W-1:0]       now_ms_i,
  // Result channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bslpc_pkg::IDX_W-1:0]        result_index_o,
  output logic                               press_edge_o,
  output logic                               release_edge_o,
  output logic                               short_press_o,
  output logic                               long_press_o,
  output logic                               index_invalid_o,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bslpc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bslpc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bslpc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                               pready
);
  import bslpc_pkg::*;

  logic [DUR_W-1:0]  long_press_ms_q;

  logic              s1_valid_q;
  logic [IDX_W-1:0]  s1_index_q;
  logic              s1_level_q;
  logic [TIME_W-1:0] s1_now_q;

  logic              out_valid_q;
  logic [IDX_W-1:0]  out_index_q;
  bslpc_evt_t        out_evt_q;

  logic              s2_free;
  logic              commit;
  bslpc_evt_t        evt;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LONG_PRESS) ?
                  {{(APB_DATA_W-DUR_W){1'b0}}, long_press_ms_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_ms_q <= LONG_PRESS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LONG_PRESS) begin
      long_press_ms_q <= pwdata[DUR_W-1:0];
    end
  end

  // Flow control between the two registers.
  assign s2_free    = ~out_valid_q | ~out_stall_i;
  assign commit     = s1_valid_q & s2_free;
  assign in_stall_o = s1_valid_q & ~s2_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_index_q <= button_index_i;
      s1_level_q <= level_i;
      s1_now_q   <= now_ms_i;
    end
  end

  // Per-button state and event decode.
  bslpc_track #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_track (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .commit_i       (commit),
    .index_i        (s1_index_q),
    .level_i        (s1_level_q),
    .now_ms_i       (s1_now_q),
    .long_press_ms_i(long_press_ms_q),
    .evt_o          (evt)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_index_q <= s1_index_q;
      out_evt_q   <= evt;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_index_o  = out_index_q;
  assign press_edge_o    = out_evt_q.press_edge;
  assign release_edge_o  = out_evt_q.release_edge;
  assign short_press_o   = out_evt_q.short_press;
  assign long_press_o    = out_evt_q.long_press;
  assign index_invalid_o = out_evt_q.index_invalid;

endmodule

// ----- sv/bslpc_checker.sv -----
// Port-level checks for the press classifier and their bind to the top level.
module bslpc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [bslpc_pkg::IDX_W-1:0] result_index_o,
  input logic                        press_edge_o,
  input logic                        release_edge_o,
  input logic                        short_press_o,
  input logic                        long_press_o,
  input logic                        index_invalid_o
);
  import bslpc_pkg::*;

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its button index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(result_index_o))
    else $error("result index changed while stalled");

  // One sample starts, ends or upgrades a press, never two of these.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({press_edge_o, release_edge_o, long_press_o}) <= 1)
    else $error("conflicting press events in one item");

  // A short press is reported only with its release.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && short_press_o |-> release_edge_o)
    else $error("short press without release edge");

  // An invalid index carries no events.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_invalid_o |->
      !press_edge_o && !release_edge_o && !short_press_o && !long_press_o)
    else $error("events on an invalid index");

endmodule

bind button_short_long_press_classifier bslpc_checker u_bslpc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .result_index_o (result_index_o),
  .press_edge_o   (press_edge_o),
  .release_edge_o (release_edge_o),
  .short_press_o  (short_press_o),
  .long_press_o   (long_press_o),
  .index_invalid_o(index_invalid_o)
);
